FILE: hw/rtl/gas_pkg.sv
// ----------------------------------------------------------------------------
// gas_pkg
// Shared types, constants and direction tables for the grid path search.
// ----------------------------------------------------------------------------
package gas_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 32;
    localparam int NCELLS     = MAX_WIDTH * MAX_HEIGHT;
    localparam int XW         = 6;
    localparam int YW         = 5;
    localparam int AW         = XW + YW;

    localparam logic [15:0] COST_STRAIGHT = 16'd10;
    localparam logic [15:0] COST_DIAG     = 16'd14;

    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_SEARCH = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam logic [1:0] KIND_NOP    = 2'd3;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    localparam logic [1:0] ST_FREE   = 2'd0;
    localparam logic [1:0] ST_OPEN   = 2'd1;
    localparam logic [1:0] ST_CLOSED = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  x;
        logic [4:0]  y;
        logic        walkable;
        logic [5:0]  goal_x;
        logic [4:0]  goal_y;
        logic [10:0] step_index;
    } t_cmd;

    typedef struct packed {
        logic        found;
        logic [11:0] path_length;
        logic [5:0]  step_x;
        logic [4:0]  step_y;
    } t_res;

    typedef struct packed {
        logic [6:0] width;
        logic [5:0] height;
    } t_geom;

    // Column offset of direction k as a 7-bit two's complement value.
    function automatic logic [6:0] f_dx(input logic [2:0] k);
        logic [6:0] d;
        case (k)
            3'd0, 3'd1, 3'd2: d = 7'h7F;
            3'd3, 3'd4:       d = 7'h00;
            default:          d = 7'h01;
        endcase
        return d;
    endfunction

    // Row offset of direction k as a 6-bit two's complement value.
    function automatic logic [5:0] f_dy(input logic [2:0] k);
        logic [5:0] d;
        case (k)
            3'd0, 3'd3, 3'd5: d = 6'h3F;
            3'd1, 3'd6:       d = 6'h00;
            default:          d = 6'h01;
        endcase
        return d;
    endfunction

    function automatic logic f_diag(input logic [2:0] k);
        logic r;
        case (k)
            3'd0, 3'd2, 3'd5, 3'd7: r = 1'b1;
            default:                r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/grid_astar_path_search_top.sv
// ----------------------------------------------------------------------------
// grid_astar_path_search_top
// A* search on an 8-connected grid with octile costs and a stored path.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser carries the item kind (cell write, search, path read),
//   tdata the coordinates, walkability and step index. Every item returns one
//   result on the output stream: found, path length, and on a read the step.
//   Configuration channel sets grid width and height; write it while idle.
// Sequence:
//   Cell write and other kinds go straight to the result. A path read of a stored
//   step first reads the path store. Search: clear the open/closed marks of all
//   cells, check the end cells, then for each expansion scan the open set over
//   width*height cells and relax up to eight neighbors, then retrace the path.
//   All of it runs through cell stores with one read and one write port each.
//   The block takes no new item until the current one is handed to the
//   output register.
// Reset:
//   A pass over all cells marks them passable; no item is taken meanwhile.
//   Found flag and path length return to zero.
// Stall:
//   A held result stays in the output register; one more item may finish
//   behind it, then the block waits.
// ----------------------------------------------------------------------------
module grid_astar_path_search_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [5:0] x, [10:6] y, [11] walkable, [17:12] goal_x, [22:18] goal_y,
    // [33:23] step_index, [39:34] zero
    input  logic [39:0] i_s_tdata,
    // [1:0] kind
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [11:0] path_length, [17:12] step_x, [22:18] step_y, [23] zero
    output logic [23:0] o_m_tdata,
    // [0] found
    output logic        o_m_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);
    logic [6:0]     r_gw;
    logic [5:0]     r_gh;
    gas_pkg::t_geom geom;
    gas_pkg::t_cmd  cmd;
    gas_pkg::t_res  res;
    logic           res_valid, res_ready;
    logic           r_ov;
    gas_pkg::t_res  r_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= 7'd40;
            r_gh <= 6'd20;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gas_pkg::REG_WIDTH:  r_gw <= i_cfg_data;
                gas_pkg::REG_HEIGHT: r_gh <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Clamp the grid size into 1..max
    always_comb begin
        if (r_gw == 7'd0)                         geom.width = 7'd1;
        else if (r_gw > 7'(gas_pkg::MAX_WIDTH))   geom.width = 7'(gas_pkg::MAX_WIDTH);
        else                                      geom.width = r_gw;
        if (r_gh == 6'd0)                         geom.height = 6'd1;
        else if (r_gh > 6'(gas_pkg::MAX_HEIGHT))  geom.height = 6'(gas_pkg::MAX_HEIGHT);
        else                                      geom.height = r_gh;
    end

    assign cmd.kind       = i_s_tuser;
    assign cmd.x          = i_s_tdata[5:0];
    assign cmd.y          = i_s_tdata[10:6];
    assign cmd.walkable   = i_s_tdata[11];
    assign cmd.goal_x     = i_s_tdata[17:12];
    assign cmd.goal_y     = i_s_tdata[22:18];
    assign cmd.step_index = i_s_tdata[33:23];

    gas_search u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom      (geom),
        .i_cmd_valid (i_s_tvalid),
        .o_cmd_ready (o_s_tready),
        .i_cmd       (cmd),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_ov || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) r_out <= res;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_out.found;
    assign o_m_tdata  = {1'b0, r_out.step_y, r_out.step_x, r_out.path_length};

endmodule

FILE: hw/rtl/gas_octile.sv
// ----------------------------------------------------------------------------
// gas_octile
// Octile distance between two cells: 10 per straight, 14 per diagonal step.
// ----------------------------------------------------------------------------
module gas_octile (
    input  logic [5:0] i_ax,
    input  logic [4:0] i_ay,
    input  logic [5:0] i_bx,
    input  logic [4:0] i_by,
    output logic [9:0] o_cost
);
    logic [5:0] dx;
    logic [5:0] dy;
    logic [5:0] mx;
    logic [5:0] mn;

    always_comb begin
        dx = (i_ax > i_bx) ? (i_ax - i_bx) : (i_bx - i_ax);
        dy = (i_ay > i_by) ? {1'b0, i_ay - i_by} : {1'b0, i_by - i_ay};
        mx = (dx > dy) ? dx : dy;
        mn = (dx > dy) ? dy : dx;
        // 14*mn + 10*(mx-mn) = 10*mx + 4*mn
        o_cost = ({4'd0, mx} << 3) + ({4'd0, mx} << 1) + ({4'd0, mn} << 2);
    end
endmodule

FILE: hw/rtl/gas_search.sv
// ----------------------------------------------------------------------------
// gas_search
// Sequencer and cell stores: cell writes, mark clearing, open-set scan, neighbor
// relaxation, path retrace and path reads, all through one read port per store.
// ----------------------------------------------------------------------------
module gas_search (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gas_pkg::t_geom i_geom,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  gas_pkg::t_cmd i_cmd,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output gas_pkg::t_res o_res
);
    typedef enum logic [14:0] {
        S_INIT     = 15'h0001,
        S_IDLE     = 15'h0002,
        S_CLR      = 15'h0004,
        S_CHK_S    = 15'h0008,
        S_CHK_G    = 15'h0010,
        S_CHK_E    = 15'h0020,
        S_SCAN     = 15'h0040,
        S_SCAN_END = 15'h0080,
        S_PICK     = 15'h0100,
        S_NB_RD    = 15'h0200,
        S_NB_EV    = 15'h0400,
        S_RET_W    = 15'h0800,
        S_RET_P    = 15'h1000,
        S_RD_WAIT  = 15'h2000,
        S_DONE     = 15'h4000
    } t_state;

    localparam int AW = gas_pkg::AW;

    t_state r_state, n_state;

    // Cell stores
    logic        r_walk_mem [gas_pkg::NCELLS];
    logic [1:0]  r_st_mem   [gas_pkg::NCELLS];
    logic [15:0] r_g_mem    [gas_pkg::NCELLS];
    logic [9:0]  r_h_mem    [gas_pkg::NCELLS];
    logic [2:0]  r_par_mem  [gas_pkg::NCELLS];
    logic [11:0] r_ord_mem  [gas_pkg::NCELLS];
    logic [10:0] r_path_mem [gas_pkg::NCELLS];

    logic        r_walk_q;
    logic [1:0]  r_st_q;
    logic [15:0] r_g_q;
    logic [9:0]  r_h_q;
    logic [2:0]  r_par_q;
    logic [11:0] r_ord_q;
    logic [10:0] r_path_q;

    // Control and payload registers
    logic [AW-1:0] r_sweep;
    logic [5:0]    r_sx, r_gx, r_cx;
    logic [4:0]    r_sy, r_gy, r_cy;
    logic          r_ws;
    logic          r_pv;
    logic [AW-1:0] r_pidx;
    logic          r_bvld;
    logic [16:0]   r_bf;
    logic [9:0]    r_bh;
    logic [11:0]   r_bo;
    logic [AW-1:0] r_bidx;
    logic [15:0]   r_bg;
    logic [2:0]    r_k;
    logic [AW-1:0] r_n;
    logic [11:0]   r_ins;
    logic [AW-1:0] r_c;
    logic [11:0]   r_j;
    logic          r_found;
    logic [11:0]   r_count;
    logic [5:0]    r_stx;
    logic [4:0]    r_sty;

    // Store access
    logic [AW-1:0] ra, wa, par_ra, path_wa, path_ra;
    logic          we_walk, wd_walk, we_st, we_cost, we_ord, we_path;
    logic [1:0]    wd_st;
    logic [15:0]   wd_g;
    logic [2:0]    wd_par;

    logic [AW-1:0] start_idx, goal_idx, nb_idx;
    logic [6:0]    nx7, cx7;
    logic [5:0]    ny6, cy6;
    logic          nb_in;
    logic [5:0]    oa_x;
    logic [4:0]    oa_y;
    logic [9:0]    oct;
    logic [16:0]   fi;
    logic          better;
    logic [15:0]   nc;
    logic          nb_upd;
    logic          scan_last;
    logic [11:0]   rd_addr;

    assign start_idx = {r_sy, r_sx};
    assign goal_idx  = {r_gy, r_gx};

    // Neighbor of the expanded cell; a step off the low edge wraps above the grid
    assign nx7   = {1'b0, r_bidx[5:0]} + gas_pkg::f_dx(r_k);
    assign ny6   = {1'b0, r_bidx[10:6]} + gas_pkg::f_dy(r_k);
    assign nb_in = (nx7 < i_geom.width) && (ny6 < i_geom.height);
    assign nb_idx = {ny6[4:0], nx7[5:0]};

    // Predecessor during retrace
    assign cx7 = {1'b0, r_c[5:0]} - gas_pkg::f_dx(r_par_q);
    assign cy6 = {1'b0, r_c[10:6]} - gas_pkg::f_dy(r_par_q);

    assign oa_x = (r_state == S_CHK_E) ? r_sx : r_n[5:0];
    assign oa_y = (r_state == S_CHK_E) ? r_sy : r_n[10:6];

    gas_octile u_octile (
        .i_ax   (oa_x),
        .i_ay   (oa_y),
        .i_bx   (r_gx),
        .i_by   (r_gy),
        .o_cost (oct)
    );

    assign fi     = {1'b0, r_g_q} + {7'd0, r_h_q};
    assign better = !r_bvld || (fi < r_bf) ||
                    ((fi == r_bf) && ((r_h_q < r_bh) ||
                     ((r_h_q == r_bh) && (r_ord_q < r_bo))));

    assign nc     = r_bg + (gas_pkg::f_diag(r_k) ? gas_pkg::COST_DIAG
                                                  : gas_pkg::COST_STRAIGHT);
    assign nb_upd = r_walk_q && (r_st_q != gas_pkg::ST_CLOSED) &&
                    ((nc < r_g_q) || (r_st_q != gas_pkg::ST_OPEN));

    assign scan_last = ({1'b0, r_cx} == i_geom.width - 7'd1) &&
                       ({1'b0, r_cy} == i_geom.height - 6'd1);

    assign rd_addr = r_count - 12'd1 - {1'b0, i_cmd.step_index};

    always_comb begin
        ra      = r_n;
        wa      = r_n;
        par_ra  = r_c;
        path_wa = r_j[AW-1:0];
        path_ra = rd_addr[AW-1:0];
        we_walk = 1'b0;
        wd_walk = 1'b1;
        we_st   = 1'b0;
        wd_st   = gas_pkg::ST_FREE;
        we_cost = 1'b0;
        we_ord  = 1'b0;
        we_path = 1'b0;
        wd_g    = nc;
        wd_par  = r_k;
        case (r_state)
            S_INIT: begin
                wa      = r_sweep;
                we_walk = 1'b1;
                we_st   = 1'b1;
            end
            S_IDLE: begin
                wa      = {i_cmd.y, i_cmd.x};
                wd_walk = i_cmd.walkable;
                we_walk = i_cmd_valid && (i_cmd.kind == gas_pkg::KIND_WRITE);
            end
            S_CLR: begin
                wa    = r_sweep;
                we_st = 1'b1;
            end
            S_CHK_S: ra = start_idx;
            S_CHK_G: ra = goal_idx;
            S_CHK_E: begin
                wa      = start_idx;
                wd_st   = gas_pkg::ST_OPEN;
                wd_g    = '0;
                we_st   = r_ws && r_walk_q;
                we_cost = r_ws && r_walk_q;
                we_ord  = r_ws && r_walk_q;
            end
            S_SCAN: ra = {r_cy, r_cx};
            S_PICK: begin
                wa    = r_bidx;
                wd_st = gas_pkg::ST_CLOSED;
                we_st = r_bvld;
            end
            S_NB_RD: ra = nb_idx;
            S_NB_EV: begin
                wd_st   = gas_pkg::ST_OPEN;
                we_cost = nb_upd;
                we_st   = nb_upd && (r_st_q != gas_pkg::ST_OPEN);
                we_ord  = nb_upd && (r_st_q != gas_pkg::ST_OPEN);
            end
            S_RET_W: we_path = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_walk) r_walk_mem[wa] <= wd_walk;
        r_walk_q <= r_walk_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (we_st) r_st_mem[wa] <= wd_st;
        r_st_q <= r_st_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (we_cost) begin
            r_g_mem[wa]   <= wd_g;
            r_h_mem[wa]   <= oct;
            r_par_mem[wa] <= wd_par;
        end
        r_g_q   <= r_g_mem[ra];
        r_h_q   <= r_h_mem[ra];
        r_par_q <= r_par_mem[par_ra];
    end

    always_ff @(posedge i_clk) begin
        if (we_ord) r_ord_mem[wa] <= r_ins;
        r_ord_q <= r_ord_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (we_path) r_path_mem[path_wa] <= r_c;
        r_path_q <= r_path_mem[path_ra];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT:     if (&r_sweep) n_state = S_IDLE;
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        gas_pkg::KIND_SEARCH: n_state = S_CLR;
                        gas_pkg::KIND_READ:
                            n_state = ({1'b0, i_cmd.step_index} < r_count) ?
                                      S_RD_WAIT : S_DONE;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_CLR: begin
                if (&r_sweep) begin
                    if (({1'b0, r_sx} >= i_geom.width) ||
                        ({1'b0, r_sy} >= i_geom.height) ||
                        ({1'b0, r_gx} >= i_geom.width) ||
                        ({1'b0, r_gy} >= i_geom.height))
                        n_state = S_DONE;
                    else
                        n_state = S_CHK_S;
                end
            end
            S_CHK_S:    n_state = S_CHK_G;
            S_CHK_G:    n_state = S_CHK_E;
            S_CHK_E:    n_state = (r_ws && r_walk_q) ? S_SCAN : S_DONE;
            S_SCAN:     if (scan_last) n_state = S_SCAN_END;
            S_SCAN_END: n_state = S_PICK;
            S_PICK: begin
                if (!r_bvld)                 n_state = S_DONE;
                else if (r_bidx == goal_idx) n_state = S_RET_W;
                else                         n_state = S_NB_RD;
            end
            S_NB_RD: begin
                if (nb_in)          n_state = S_NB_EV;
                else if (&r_k)      n_state = S_SCAN;
            end
            S_NB_EV:    n_state = (&r_k) ? S_SCAN : S_NB_RD;
            S_RET_W: begin
                if ((r_c == start_idx) || (r_j == 12'(gas_pkg::NCELLS - 1)))
                    n_state = S_DONE;
                else
                    n_state = S_RET_P;
            end
            S_RET_P: begin
                if (cx7 >= 7'(gas_pkg::MAX_WIDTH) || cy6 >= 6'(gas_pkg::MAX_HEIGHT))
                    n_state = S_DONE;
                else
                    n_state = S_RET_W;
            end
            S_RD_WAIT:  n_state = S_DONE;
            S_DONE:     if (i_res_ready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_sweep <= '0;
            r_found <= 1'b0;
            r_count <= '0;
            r_pv    <= 1'b0;
            r_bvld  <= 1'b0;
            r_ins   <= '0;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state == S_SCAN);
            if (r_state == S_INIT || r_state == S_CLR)
                r_sweep <= r_sweep + AW'(1);
            // Track the best open cell in the cycle after its scan address
            if (r_pv && (r_st_q == gas_pkg::ST_OPEN) && better) begin
                r_bvld <= 1'b1;
                r_bf   <= fi;
                r_bh   <= r_h_q;
                r_bo   <= r_ord_q;
                r_bidx <= r_pidx;
                r_bg   <= r_g_q;
            end
            r_pidx <= {r_cy, r_cx};
            case (r_state)
                S_IDLE: begin
                    r_stx <= '0;
                    r_sty <= '0;
                    if (i_cmd_valid && (i_cmd.kind == gas_pkg::KIND_SEARCH)) begin
                        r_sx    <= i_cmd.x;
                        r_sy    <= i_cmd.y;
                        r_gx    <= i_cmd.goal_x;
                        r_gy    <= i_cmd.goal_y;
                        r_found <= 1'b0;
                        r_count <= '0;
                        r_sweep <= '0;
                        r_ins   <= '0;
                    end
                end
                S_CHK_G: r_ws <= r_walk_q;
                S_CHK_E: begin
                    r_ins  <= 12'd1;
                    r_cx   <= '0;
                    r_cy   <= '0;
                    r_bvld <= 1'b0;
                end
                S_SCAN: begin
                    if ({1'b0, r_cx} == i_geom.width - 7'd1) begin
                        r_cx <= '0;
                        r_cy <= r_cy + 5'd1;
                    end else begin
                        r_cx <= r_cx + 6'd1;
                    end
                end
                S_PICK: begin
                    r_k <= '0;
                    r_c <= goal_idx;
                    r_j <= '0;
                end
                S_NB_RD: begin
                    r_n <= nb_idx;
                    if (!nb_in) begin
                        r_k <= r_k + 3'd1;
                        if (&r_k) begin
                            r_cx   <= '0;
                            r_cy   <= '0;
                            r_bvld <= 1'b0;
                        end
                    end
                end
                S_NB_EV: begin
                    if (nb_upd && (r_st_q != gas_pkg::ST_OPEN))
                        r_ins <= r_ins + 12'd1;
                    r_k <= r_k + 3'd1;
                    if (&r_k) begin
                        r_cx   <= '0;
                        r_cy   <= '0;
                        r_bvld <= 1'b0;
                    end
                end
                S_RET_W: begin
                    r_j <= r_j + 12'd1;
                    if ((r_c == start_idx) || (r_j == 12'(gas_pkg::NCELLS - 1))) begin
                        r_found <= 1'b1;
                        r_count <= r_j + 12'd1;
                    end
                end
                S_RET_P: begin
                    if (cx7 >= 7'(gas_pkg::MAX_WIDTH) || cy6 >= 6'(gas_pkg::MAX_HEIGHT)) begin
                        r_found <= 1'b1;
                        r_count <= r_j;
                    end else begin
                        r_c <= {cy6[4:0], cx7[5:0]};
                    end
                end
                S_RD_WAIT: begin
                    r_stx <= r_path_q[5:0];
                    r_sty <= r_path_q[10:6];
                end
                default: ;
            endcase
        end
    end

    assign o_cmd_ready       = (r_state == S_IDLE);
    assign o_res_valid       = (r_state == S_DONE);
    assign o_res.found       = r_found;
    assign o_res.path_length = r_count;
    assign o_res.step_x      = r_stx;
    assign o_res.step_y      = r_sty;

    a_found_has_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_count != 12'd0))
        else $error("found flag set with empty path");

    a_scan_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_state == S_SCAN || r_state == S_SCAN_END))
        else $error("scan data outside scan");

    a_ins_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ins <= 12'(gas_pkg::NCELLS))
        else $error("insert counter beyond cell count");

endmodule
